/* design/assert_macros.svh */
// Assertion macros shared by the design files. Both use the clock clk and the
// active-low reset rst_n of the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/wssd_pkg.sv */
`timescale 1ns / 1ps

package wssd_pkg;

    localparam int TEMP_W     = 16;
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 20;
    localparam int LIMIT_W    = 16;
    localparam int COUNT_W    = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_TIME_STEP   = 1'b0;
    localparam logic REG_SLOPE_LIMIT = 1'b1;

    localparam logic [STEP_W-1:0]  TIME_STEP_RESET   = 20'd5000;
    localparam logic [LIMIT_W-1:0] SLOPE_LIMIT_RESET = 16'd102;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [TIME_W-1:0]        sample_time_ms;
    } sample_t;

    typedef struct packed {
        logic               stored;
        logic               stable;
        logic [COUNT_W-1:0] window_count;
    } result_t;

endpackage

/* design/wssd_ram.sv */
`timescale 1ns / 1ps

module wssd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/window_slope_stability_detector_core.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                       Payload
// sample    in         sample_valid / sample_ready     wssd_pkg::sample_t
// result    out        result_valid / result_ready     wssd_pkg::result_t
// config    in         APB psel, penable, pwrite       paddr, pwdata, prdata
//
// Each sample passes in order through the states DECIDE, WALK, MUL1, MUL2, MUL3, MUL4, CMP
// and DONE, and no new sample is taken until it has left DONE; the walk is set by the single
// read port of the window memory, which is walked one entry a cycle.
// With fewer than two samples held the walk is skipped and the sample goes straight to DONE.
// Reset clears the control state at once; the window memory is not cleared.
// A finished result waits in the output register while the next sample is taken in.

`include "assert_macros.svh"

module window_slope_stability_detector_core #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  wssd_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output wssd_pkg::result_t                   result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wssd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wssd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wssd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int PTRW = $clog2(WINDOW_DEPTH);
    localparam int HW   = $clog2(WINDOW_DEPTH + 1);
    localparam int SXW  = $clog2(WINDOW_DEPTH * (WINDOW_DEPTH + 1) / 2 + 1);
    localparam int SXXW = $clog2(WINDOW_DEPTH * (WINDOW_DEPTH + 1) * (2 * WINDOW_DEPTH + 1) / 6 + 1);
    localparam int SYW  = wssd_pkg::TEMP_W + HW;
    localparam int XYW  = wssd_pkg::TEMP_W + HW + 1;
    localparam int SXYW = wssd_pkg::TEMP_W + 1 + 2 * HW;
    localparam int M1W  = HW + SXYW + 1;
    localparam int M2W  = SXW + SYW + 1;
    localparam int M3W  = HW + SXXW;
    localparam int M4W  = 2 * SXW;
    localparam int PW12 = (M1W > M2W) ? M1W : M2W;
    localparam int PW34 = (M3W > M4W) ? M3W : M4W;
    localparam int PW   = ((PW12 > PW34) ? PW12 : PW34) + 1;
    localparam int DENW = HW + SXXW + 1;
    localparam int LPW  = wssd_pkg::LIMIT_W + DENW;
    localparam int CW   = ((PW + 6 > LPW) ? PW + 6 : LPW) + 1;

    localparam logic [HW-1:0]   DEPTH_H   = HW'(WINDOW_DEPTH);
    localparam logic [HW:0]     DEPTH_X   = (HW + 1)'(WINDOW_DEPTH);
    localparam logic [PTRW-1:0] LAST_POS  = PTRW'(WINDOW_DEPTH - 1);
    localparam logic [HW-1:0]   TWO_H     = HW'(2);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECIDE = 9'b000000010,
        ST_WALK   = 9'b000000100,
        ST_MUL1   = 9'b000001000,
        ST_MUL2   = 9'b000010000,
        ST_MUL3   = 9'b000100000,
        ST_MUL4   = 9'b001000000,
        ST_CMP    = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [wssd_pkg::STEP_W-1:0]  time_step_reg;
    logic [wssd_pkg::LIMIT_W-1:0] slope_limit_reg;

    wssd_pkg::sample_t sample_reg;
    logic [PTRW-1:0]   oldest_reg, oldest_next;
    logic [HW-1:0]     held_reg, held_next;
    logic [wssd_pkg::TIME_W-1:0] last_time_reg, last_time_next;
    logic              have_reg, have_next;
    logic              stored_reg, stored_next;
    logic              stable_reg, stable_next;

    logic [PTRW-1:0] rd_addr_reg, rd_addr_next;
    logic [HW-1:0]   rd_cnt_reg, rd_cnt_next;
    logic            vld1_reg, vld2_reg;
    logic [HW-1:0]   x1_reg, x2_reg;
    logic signed [XYW-1:0]  xy_reg, xy_next;
    logic [2*HW-1:0]        xx_reg, xx_next;
    logic signed [wssd_pkg::TEMP_W-1:0] y2_reg;

    logic [SXW-1:0]          sx_reg, sx_next;
    logic [SXXW-1:0]         sxx_reg, sxx_next;
    logic signed [SYW-1:0]   sy_reg, sy_next;
    logic signed [SXYW-1:0]  sxy_reg, sxy_next;

    logic signed [PW-1:0] pa_reg, pa_next;
    logic signed [PW-1:0] pb_reg, pb_next;
    logic signed [PW-1:0] num_reg, num_next;
    logic signed [PW-1:0] diff;
    logic [PW-1:0]        anum_reg, anum_next;
    logic [DENW-1:0]      den_reg, den_next;
    logic [LPW-1:0]       lim_prod_reg, lim_prod_next;

    logic signed [M1W-1:0] m_nsxy;
    logic signed [M2W-1:0] m_sxsy;
    logic [M3W-1:0]        m_nsxx;
    logic [M4W-1:0]        m_sxsx;

    logic                  out_valid_reg, out_valid_next;
    wssd_pkg::result_t     out_reg, out_next;
    logic                  out_load;

    logic [wssd_pkg::TIME_W-1:0] elapsed;
    logic                  store;
    logic                  held_full;
    logic [HW:0]           wpos_sum;
    logic [PTRW-1:0]       wpos;
    logic [HW-1:0]         held_after;
    logic                  issue;
    logic                  mem_we;
    logic [wssd_pkg::TEMP_W-1:0] mem_rdata;
    logic [HW+wssd_pkg::COUNT_W-1:0] count_ext;
    logic                  cfg_write;

    wssd_ram #(
        .WIDTH (wssd_pkg::TEMP_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wpos),
        .wdata (sample_reg.temperature),
        .re    (issue),
        .raddr (rd_addr_reg),
        .rdata (mem_rdata)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            wssd_pkg::REG_TIME_STEP:
                prdata = wssd_pkg::APB_DATA_W'(time_step_reg);
            wssd_pkg::REG_SLOPE_LIMIT:
                prdata = wssd_pkg::APB_DATA_W'(slope_limit_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg   <= wssd_pkg::TIME_STEP_RESET;
            slope_limit_reg <= wssd_pkg::SLOPE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                wssd_pkg::REG_TIME_STEP:
                    time_step_reg <= pwdata[wssd_pkg::STEP_W-1:0];
                wssd_pkg::REG_SLOPE_LIMIT:
                    slope_limit_reg <= pwdata[wssd_pkg::LIMIT_W-1:0];
                default:
                    time_step_reg <= time_step_reg;
            endcase
        end
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign elapsed   = sample_reg.sample_time_ms - last_time_reg;
    assign store     = !have_reg
                       || (elapsed >= wssd_pkg::TIME_W'(time_step_reg));
    assign held_full = (held_reg == DEPTH_H);
    assign wpos_sum  = (HW + 1)'(oldest_reg) + (HW + 1)'(held_reg);
    assign held_after = (store && !held_full) ? held_reg + 1'b1 : held_reg;
    assign mem_we    = (state_reg == ST_DECIDE) && store;
    assign issue     = (state_reg == ST_WALK) && (rd_cnt_reg < held_reg);
    assign count_ext = (HW + wssd_pkg::COUNT_W)'(held_reg);

    always_comb
    begin
        if (held_full)
        begin
            wpos = oldest_reg;
        end
        else if (wpos_sum >= DEPTH_X)
        begin
            wpos = PTRW'(wpos_sum - DEPTH_X);
        end
        else
        begin
            wpos = PTRW'(wpos_sum);
        end
    end

    assign xy_next = XYW'($signed(mem_rdata)) * XYW'($signed({1'b0, x1_reg}));
    assign xx_next = (2 * HW)'(x1_reg) * (2 * HW)'(x1_reg);
    assign m_nsxy  = M1W'($signed({1'b0, held_reg})) * M1W'(sxy_reg);
    assign m_sxsy  = M2W'($signed({1'b0, sx_reg})) * M2W'(sy_reg);
    assign m_nsxx  = M3W'(held_reg) * M3W'(sxx_reg);
    assign m_sxsx  = M4W'(sx_reg) * M4W'(sx_reg);
    assign diff    = pa_reg - pb_reg;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        held_next      = held_reg;
        last_time_next = last_time_reg;
        have_next      = have_reg;
        stored_next    = stored_reg;
        stable_next    = stable_reg;
        rd_addr_next   = rd_addr_reg;
        rd_cnt_next    = rd_cnt_reg;
        sx_next        = sx_reg;
        sxx_next       = sxx_reg;
        sy_next        = sy_reg;
        sxy_next       = sxy_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        num_next       = num_reg;
        anum_next      = anum_reg;
        den_next       = den_reg;
        lim_prod_next  = lim_prod_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (vld2_reg)
        begin
            sx_next  = sx_reg + SXW'(x2_reg);
            sxx_next = sxx_reg + SXXW'(xx_reg);
            sy_next  = sy_reg + SYW'(y2_reg);
            sxy_next = sxy_reg + SXYW'(xy_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                stored_next = store;
                stable_next = 1'b0;
                if (store)
                begin
                    last_time_next = sample_reg.sample_time_ms;
                    have_next      = 1'b1;
                    held_next      = held_after;
                    if (held_full)
                    begin
                        oldest_next = (oldest_reg == LAST_POS) ? '0 : oldest_reg + 1'b1;
                    end
                end
                rd_addr_next = oldest_next;
                rd_cnt_next  = '0;
                sx_next      = '0;
                sxx_next     = '0;
                sy_next      = '0;
                sxy_next     = '0;
                state_next   = (held_after < TWO_H) ? ST_DONE : ST_WALK;
            end
            ST_WALK:
            begin
                if (issue)
                begin
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                    rd_addr_next = (rd_addr_reg == LAST_POS) ? '0 : rd_addr_reg + 1'b1;
                end
                else if (!vld1_reg && !vld2_reg)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                pa_next    = PW'(m_nsxy);
                pb_next    = PW'(m_sxsy);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                num_next   = diff;
                pa_next    = PW'(m_nsxx);
                pb_next    = PW'(m_sxsx);
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                den_next   = diff[DENW-1:0];
                anum_next  = num_reg[PW-1] ? PW'(-num_reg) : PW'(num_reg);
                state_next = ST_MUL4;
            end
            ST_MUL4:
            begin
                lim_prod_next = LPW'(slope_limit_reg) * LPW'(den_reg);
                state_next    = ST_CMP;
            end
            ST_CMP:
            begin
                stable_next = CW'({anum_reg, 6'b000000}) < CW'(lim_prod_reg);
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next        = 1'b1;
                    out_next.stored       = stored_reg;
                    out_next.stable       = stable_reg;
                    out_next.window_count = count_ext[wssd_pkg::COUNT_W-1:0];
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            held_reg      <= '0;
            last_time_reg <= '0;
            have_reg      <= 1'b0;
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            held_reg      <= held_next;
            last_time_reg <= last_time_next;
            have_reg      <= have_next;
            vld1_reg      <= issue;
            vld2_reg      <= vld1_reg;
            rd_cnt_reg    <= rd_cnt_next;
            rd_addr_reg   <= rd_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            sample_reg <= sample;
        end
        x1_reg       <= rd_cnt_reg + 1'b1;
        x2_reg       <= x1_reg;
        xy_reg       <= xy_next;
        xx_reg       <= xx_next;
        y2_reg       <= $signed(mem_rdata);
        stored_reg   <= stored_next;
        stable_reg   <= stable_next;
        sx_reg       <= sx_next;
        sxx_reg      <= sxx_next;
        sy_reg       <= sy_next;
        sxy_reg      <= sxy_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        num_reg      <= num_next;
        anum_reg     <= anum_next;
        den_reg      <= den_next;
        lim_prod_reg <= lim_prod_next;
        out_reg      <= out_next;
    end

    `ASSERT_SAME(a_held_bound, 1'b1, held_reg <= DEPTH_H, "Window holds more samples than its depth.")
    `ASSERT_SAME(a_idle_drained, state_reg == ST_IDLE, !vld1_reg && !vld2_reg, "Window read pipeline busy while idle.")
    `ASSERT_NEXT(a_store_grows, mem_we && !held_full, held_reg == $past(held_reg) + 1'b1, "Stored sample did not raise the count.")
    `ASSERT_SAME(a_result_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE), "Result raised outside the final state.")

endmodule
